@@ rtl/sirds_pkg.sv @@
package sirds_pkg;

    localparam int MAX_WIDTH_DEF  = 256;
    localparam int VALUE_BITS_DEF = 24;
    localparam int COEF_BITS      = 16;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_IDX_BITS-1:0] REG_GRID_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_GRID_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_INFECT_RATE  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_RECOVER_RATE = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_DIFFUSE_S    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_DIFFUSE_I    = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_DIFFUSE_R    = 3'd6;

    localparam logic OP_CELL  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

endpackage

@@ rtl/sir_diffusion_stencil_sweep_unit.sv @@
// channel  | handshake            | payload
// ---------+----------------------+-----------------------------------
// input    | in_valid / in_stall  | op, s_in, i_in, r_in
// output   | out_valid / out_stall| s_out, i_out, r_out, frame_end
// config   | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Each beat passes through accept with row-store read, laplacians and S*I,
// coefficient products and the result stage, one read/modify/write pass
// through the row stores. A beat that yields a result holds the input
// until the output register is taken. Reset restores register defaults
// and clears counters, bank select and valid flags; row stores are not
// cleared.
module sir_diffusion_stencil_sweep_unit
    import sirds_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         op,
    input  logic signed [VALUE_BITS-1:0] s_in,
    input  logic signed [VALUE_BITS-1:0] i_in,
    input  logic signed [VALUE_BITS-1:0] r_in,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [VALUE_BITS-1:0] s_out,
    output logic signed [VALUE_BITS-1:0] i_out,
    output logic signed [VALUE_BITS-1:0] r_out,
    output logic                         frame_end,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [CFG_DATA_BITS-1:0]     cfg_data
);

    localparam int CW   = $clog2(MAX_WIDTH + 1);
    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int AW   = XW + 1;
    localparam int FRAC = VALUE_BITS - 4;
    localparam int LW   = VALUE_BITS + 3;
    localparam int PW   = LW + COEF_BITS + 1;
    localparam int WW   = VALUE_BITS + 5;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_SUM  = 2'd3;

    typedef logic signed [VALUE_BITS-1:0] val_t;

    // configuration
    logic [8:0]  grid_width_reg;
    logic [15:0] grid_height_reg;
    logic [15:0] infect_rate_reg, recover_rate_reg;
    logic [15:0] diffuse_s_reg, diffuse_i_reg, diffuse_r_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg   <= 9'd100;
            grid_height_reg  <= 16'd100;
            infect_rate_reg  <= 16'd13107;
            recover_rate_reg <= 16'd655;
            diffuse_s_reg    <= 16'd655;
            diffuse_i_reg    <= 16'd655;
            diffuse_r_reg    <= 16'd655;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_GRID_WIDTH:   grid_width_reg   <= cfg_data[8:0];
                REG_GRID_HEIGHT:  grid_height_reg  <= cfg_data;
                REG_INFECT_RATE:  infect_rate_reg  <= cfg_data;
                REG_RECOVER_RATE: recover_rate_reg <= cfg_data;
                REG_DIFFUSE_S:    diffuse_s_reg    <= cfg_data;
                REG_DIFFUSE_I:    diffuse_i_reg    <= cfg_data;
                REG_DIFFUSE_R:    diffuse_r_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // effective dimensions
    logic [CW-1:0] w_eff;
    logic [15:0]   h_eff;
    always_comb
    begin
        if (grid_width_reg < 9'd3)
            w_eff = CW'(3);
        else if (32'(grid_width_reg) > MAX_WIDTH)
            w_eff = CW'(MAX_WIDTH);
        else
            w_eff = CW'(grid_width_reg);
        h_eff = (grid_height_reg < 16'd3) ? 16'd3 : grid_height_reg;
    end

    // control state
    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] col_reg;
    logic [15:0]   row_reg;
    logic          bank_reg;

    logic [CW-1:0] col_c;
    logic [15:0]   row_c;
    logic          last_col;
    always_comb
    begin
        col_c    = (col_reg > w_eff - CW'(1)) ? w_eff - CW'(1) : col_reg;
        row_c    = (row_reg > h_eff) ? h_eff : row_reg;
        last_col = (col_c == w_eff - CW'(1));
    end

    logic accept;
    assign in_stall = (state_reg != ST_IDLE) || out_valid;
    assign accept   = in_valid && !in_stall;

    // latched item
    logic          flush_reg, emit_reg, interior_reg, fend_reg;
    val_t          s_reg, i_reg, r_reg;
    logic [AW-1:0] up_base;
    logic [XW-1:0] cx;
    assign cx      = col_c[XW-1:0];
    assign up_base = {~bank_reg, {XW{1'b0}}};

    logic           is_flush, row_ok, emit, wr;
    always_comb
    begin
        is_flush = (op == OP_FLUSH);
        row_ok   = is_flush ? (row_c >= h_eff) : (row_c < h_eff);
        emit     = row_ok && (is_flush || row_c >= 16'd1);
        wr       = accept && !is_flush && row_ok;
    end

    logic [AW-1:0] a_n, a_w, a_c, a_e, a_wr;
    always_comb
    begin
        a_c  = up_base | AW'(cx);
        a_w  = up_base | AW'(cx - XW'(1));
        a_e  = up_base | AW'(cx + XW'(1));
        a_n  = {bank_reg, cx};
        a_wr = {bank_reg, cx};
    end

    val_t sn, sw, sc, se, in_n, iw, ic, ie, rn, rw, rc, re_;

    sirds_bank #(.MAX_WIDTH(MAX_WIDTH), .VALUE_BITS(VALUE_BITS)) u_bank_s (
        .clk, .we(wr), .waddr(a_wr), .wdata(s_in), .re(accept),
        .raddr_n(a_n), .raddr_w(a_w), .raddr_c(a_c), .raddr_e(a_e),
        .rdata_n(sn), .rdata_w(sw), .rdata_c(sc), .rdata_e(se));
    sirds_bank #(.MAX_WIDTH(MAX_WIDTH), .VALUE_BITS(VALUE_BITS)) u_bank_i (
        .clk, .we(wr), .waddr(a_wr), .wdata(i_in), .re(accept),
        .raddr_n(a_n), .raddr_w(a_w), .raddr_c(a_c), .raddr_e(a_e),
        .rdata_n(in_n), .rdata_w(iw), .rdata_c(ic), .rdata_e(ie));
    sirds_bank #(.MAX_WIDTH(MAX_WIDTH), .VALUE_BITS(VALUE_BITS)) u_bank_r (
        .clk, .we(wr), .waddr(a_wr), .wdata(r_in), .re(accept),
        .raddr_n(a_n), .raddr_w(a_w), .raddr_c(a_c), .raddr_e(a_e),
        .rdata_n(rn), .rdata_w(rw), .rdata_c(rc), .rdata_e(re_));
    // sn/in_n/rn: the row two above, still in the current bank at this
    // column; the registered read sees the old word before the south
    // cell's write lands on the same edge.

    // stage: laplacians and S*I product
    logic signed [LW-1:0]     lap_s_reg, lap_i_reg, lap_r_reg;
    logic signed [2*VALUE_BITS-1:0] si_full_reg;
    val_t sc_reg, ic_reg, rc_reg;

    function automatic logic signed [LW-1:0] lap(input val_t n, input val_t w,
        input val_t e, input val_t c, input val_t so);
        lap = LW'(n) + LW'(w) + LW'(e) + LW'(so) - (LW'(c) <<< 2);
    endfunction

    // stage: coefficient products
    logic signed [PW-1:0] ds_reg, di_reg, dr_reg;
    logic signed [VALUE_BITS+COEF_BITS+4:0] bsi_reg, gi_reg;

    function automatic val_t sat(input logic signed [WW-1:0] v);
        logic signed [WW-1:0] hi, lo;
        hi = WW'({1'b0, {(VALUE_BITS-1){1'b1}}});
        lo = ~hi;
        if (v > hi)
            sat = val_t'(hi);
        else if (v < lo)
            sat = val_t'(lo);
        else
            sat = val_t'(v);
    endfunction

    // S*I keeps its integer growth: full-scale factors reach 2^26
    logic signed [VALUE_BITS+3:0] si_q;
    assign si_q = (VALUE_BITS+4)'(si_full_reg >>> FRAC);

    logic signed [WW-1:0] bsi_w, gi_w, ds_w, di_w, dr_w, ns, ni, nr;
    always_comb
    begin
        bsi_w = WW'(bsi_reg >>> COEF_BITS);
        gi_w  = WW'(gi_reg >>> COEF_BITS);
        ds_w  = WW'(ds_reg >>> COEF_BITS);
        di_w  = WW'(di_reg >>> COEF_BITS);
        dr_w  = WW'(dr_reg >>> COEF_BITS);
        ns = WW'(sc_reg) - bsi_w + ds_w;
        ni = WW'(ic_reg) + bsi_w - gi_w + di_w;
        nr = WW'(rc_reg) + gi_w + dr_w;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_READ;
            ST_READ: state_next = ST_MUL;
            ST_MUL:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            bank_reg  <= 1'b0;
            out_valid <= 1'b0;
            emit_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid && !out_stall)
                out_valid <= 1'b0;
            if (accept)
            begin
                emit_reg <= emit;
                if (row_ok)
                begin
                    if (last_col)
                    begin
                        col_reg <= '0;
                        if (is_flush)
                            row_reg <= '0;
                        else
                        begin
                            row_reg  <= row_c + 16'd1;
                            bank_reg <= ~bank_reg;
                        end
                    end
                    else
                    begin
                        col_reg <= col_c + CW'(1);
                        row_reg <= row_c;
                    end
                end
            end
            if (state_reg == ST_SUM && emit_reg)
                out_valid <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            flush_reg    <= is_flush;
            interior_reg <= !is_flush && row_c >= 16'd2 && col_c != '0 && !last_col;
            fend_reg     <= is_flush && last_col;
            s_reg <= s_in;
            i_reg <= i_in;
            r_reg <= r_in;
        end
        if (state_reg == ST_READ)
        begin
            sc_reg <= sc;
            ic_reg <= ic;
            rc_reg <= rc;
            lap_s_reg   <= lap(sn, sw, se, sc, s_reg);
            lap_i_reg   <= lap(in_n, iw, ie, ic, i_reg);
            lap_r_reg   <= lap(rn, rw, re_, rc, r_reg);
            si_full_reg <= (2*VALUE_BITS)'(sc) * (2*VALUE_BITS)'(ic);
        end
        if (state_reg == ST_MUL)
        begin
            bsi_reg <= si_q * $signed({1'b0, infect_rate_reg});
            gi_reg  <= ic_reg * $signed({1'b0, recover_rate_reg});
            ds_reg  <= lap_s_reg * $signed({1'b0, diffuse_s_reg});
            di_reg  <= lap_i_reg * $signed({1'b0, diffuse_i_reg});
            dr_reg  <= lap_r_reg * $signed({1'b0, diffuse_r_reg});
        end
        if (state_reg == ST_SUM && emit_reg)
        begin
            frame_end <= fend_reg;
            if (interior_reg && !flush_reg)
            begin
                s_out <= sat(ns);
                i_out <= sat(ni);
                r_out <= sat(nr);
            end
            else
            begin
                s_out <= sc_reg;
                i_out <= ic_reg;
                r_out <= rc_reg;
            end
        end
    end

endmodule

@@ rtl/sirds_bank.sv @@
// One quantity's two row banks: write port plus four registered read ports
// (N, C above-row centre, plus W and E of the row above).
module sirds_bank
    import sirds_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    localparam int AW = $clog2(2 * MAX_WIDTH)
)
(
    input  logic                         clk,
    input  logic                         we,
    input  logic [AW-1:0]                waddr,
    input  logic signed [VALUE_BITS-1:0] wdata,
    input  logic                         re,
    input  logic [AW-1:0]                raddr_n,
    input  logic [AW-1:0]                raddr_w,
    input  logic [AW-1:0]                raddr_c,
    input  logic [AW-1:0]                raddr_e,
    output logic signed [VALUE_BITS-1:0] rdata_n,
    output logic signed [VALUE_BITS-1:0] rdata_w,
    output logic signed [VALUE_BITS-1:0] rdata_c,
    output logic signed [VALUE_BITS-1:0] rdata_e
);

    // four copies, each written together and read at one address
    logic signed [VALUE_BITS-1:0] mem_n [2*MAX_WIDTH];
    logic signed [VALUE_BITS-1:0] mem_w [2*MAX_WIDTH];
    logic signed [VALUE_BITS-1:0] mem_c [2*MAX_WIDTH];
    logic signed [VALUE_BITS-1:0] mem_e [2*MAX_WIDTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_n[waddr] <= wdata;
            mem_w[waddr] <= wdata;
            mem_c[waddr] <= wdata;
            mem_e[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_n <= mem_n[raddr_n];
            rdata_w <= mem_w[raddr_w];
            rdata_c <= mem_c[raddr_c];
            rdata_e <= mem_e[raddr_e];
        end
    end

endmodule
